// ===== src/tyuv_pkg.sv =====
// ----------------------------------------------------------------------------
// tyuv_pkg
// Types and constants of the tiled frame to linear NV12 address generator.
// ----------------------------------------------------------------------------
package tyuv_pkg;

    localparam int SIZE_W = 13;
    localparam int OFF_W  = 25;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_TILE_LAYOUT  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic LAYOUT_MB16   = 1'b0;
    localparam logic LAYOUT_TILE4  = 1'b1;
    localparam logic PLANE_LUMA    = 1'b0;
    localparam logic PLANE_CHROMA  = 1'b1;

    typedef struct packed {
        logic              plane_select;
        logic              plane_start;
        logic [BYTE_W-1:0] pixel_byte;
    } t_in_item;

    typedef struct packed {
        logic [OFF_W-1:0]  dest_offset;
        logic [BYTE_W-1:0] pixel_out;
        logic              beyond_frame;
    } t_out_item;

    // Frame size in effect: low four bits cleared, clamped to 16 .. cap.
    function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v, int cap);
        logic [SIZE_W-1:0] s;
        s = {v[SIZE_W-1:4], 4'b0000};
        if (s < SIZE_W'(16)) begin
            s = SIZE_W'(16);
        end
        if (int'(s) > cap) begin
            s = SIZE_W'(cap);
        end
        return s;
    endfunction

endpackage

// ===== src/tiled_yuv_to_nv12_address.sv =====
// ----------------------------------------------------------------------------
// tiled_yuv_to_nv12_address
// Maps the bytes of a tiled camera frame, in source order, to their byte
// offsets in a linear NV12 buffer (16x16 macroblocks or reversed 4x4 tiles).
// ----------------------------------------------------------------------------
// channel  | signals                              | handshake
// ---------+--------------------------------------+-----------------------
// input    | i_in_data (t_in_item)                | i_in_valid / o_in_ready
// output   | o_out_data (t_out_item)              | o_out_valid / i_out_ready
// config   | i_cfg_index, i_cfg_data              | i_cfg_wr_en, no wait
//
// One transaction per cycle unless the output stalls, through stages 1 and 2.
// Stage 1 holds the tile counters and the row base; stage 2 adds the plane
// base and the in-tile line times the width (one 4x13 multiplier).
// Reset clears counters and loads 0 / 1920 / 1088 into the registers.
// An output stall holds both stages; stage 1 still takes a transaction if empty.
// ----------------------------------------------------------------------------
module tiled_yuv_to_nv12_address
    import tyuv_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_wr_en,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [SIZE_W-1:0]  i_cfg_data
);

    localparam int CAP_W = ((MAX_WIDTH / 16) < 1) ? 16 : (MAX_WIDTH / 16) * 16;
    localparam int CAP_H = ((MAX_HEIGHT / 16) < 1) ? 16 : (MAX_HEIGHT / 16) * 16;
    localparam int COL_W = $clog2(MAX_WIDTH / 4);
    localparam int ROW_W = $clog2(MAX_HEIGHT / 4);

    // configuration
    logic              r_layout;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic [OFF_W-1:0]  r_plane_size;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [2*SIZE_W-1:0] plane_area;

    // counters
    logic              r_cur_plane;
    logic              r_plane_done;
    logic [7:0]        r_byte;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [OFF_W-1:0]  r_row_base;

    logic              n_plane_done;
    logic [7:0]        n_byte;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [OFF_W-1:0]  n_row_base;
    logic [OFF_W-1:0]  n_xsum;
    logic [3:0]        n_ymul;

    // stage 1
    logic              r_s1_valid;
    logic              r_s1_sel;
    logic              r_s1_done;
    logic [BYTE_W-1:0] r_s1_pix;
    logic [OFF_W-1:0]  r_s1_xsum;
    logic [3:0]        r_s1_ymul;

    // stage 2
    logic              r_out_valid;
    t_out_item         r_out;
    logic [OFF_W-1:0]  n_offset;
    logic [SIZE_W+3:0] line_off;

    logic              adv;
    logic              acc;
    logic              restart;
    logic              sel;
    logic [7:0]        b;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [OFF_W-1:0]  row_base;
    logic              done;
    logic [8:0]        tsize;
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
    logic [OFF_W-1:0]  stride;
    logic [OFF_W-1:0]  col_term;
    logic [OFF_W-1:0]  x_term;
    logic [SIZE_W-1:0] cols_cur;

    assign w_eff = eff_size(r_width, CAP_W);
    assign h_eff = eff_size(r_height, CAP_H);
    assign plane_area = {{SIZE_W{1'b0}}, w_eff} * {{SIZE_W{1'b0}}, h_eff};
    assign line_off   = {{SIZE_W{1'b0}}, r_s1_ymul} * {4'b0000, w_eff};

    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || adv;
    assign acc         = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        sel      = i_in_data.plane_select;
        restart  = i_in_data.plane_start || (sel != r_cur_plane);
        b        = restart ? 8'd0 : r_byte;
        col      = restart ? '0 : r_col;
        row      = restart ? '0 : r_row;
        row_base = restart ? '0 : r_row_base;
        done     = restart ? 1'b0 : r_plane_done;

        if (r_layout == LAYOUT_MB16) begin
            cols   = w_eff >> 4;
            rows   = h_eff >> 4;
            if (sel == PLANE_LUMA) begin
                tsize    = 9'd256;
                stride   = OFF_W'(w_eff) << 4;
                col_term = OFF_W'(col) << 4;
                x_term   = OFF_W'({b[6], b[2:0]});
                n_ymul   = {b[7], b[5:3]};
            end else begin
                tsize    = 9'd128;
                stride   = OFF_W'(w_eff) << 3;
                col_term = OFF_W'(col) << 4;
                x_term   = OFF_W'({b[2:0], b[6]});
                n_ymul   = {1'b0, b[5:3]};
            end
        end else begin
            stride = OFF_W'(w_eff) << 2;
            if (sel == PLANE_LUMA) begin
                cols     = w_eff >> 2;
                rows     = h_eff >> 2;
                tsize    = 9'd16;
                col_term = OFF_W'(col) << 2;
                x_term   = OFF_W'({~b[1:0]});
                n_ymul   = {2'b00, ~b[3:2]};
            end else begin
                cols     = w_eff >> 3;
                rows     = h_eff >> 3;
                tsize    = 9'd32;
                col_term = OFF_W'(col) << 3;
                x_term   = OFF_W'({~b[2:1], ~b[0]});
                n_ymul   = {2'b00, b[4:3]};
            end
        end

        n_xsum       = row_base + col_term + x_term;
        n_plane_done = done;
        n_byte       = b;
        n_col        = col;
        n_row        = row;
        n_row_base   = row_base;
        if (!done) begin
            n_byte = b + 8'd1;
            if ({1'b0, b} + 9'd1 >= tsize) begin
                n_byte = 8'd0;
                n_col  = col + 1'b1;
                if ((SIZE_W + 1)'(col) + 1'b1 >= (SIZE_W + 1)'(cols)) begin
                    n_col      = '0;
                    n_row      = row + 1'b1;
                    n_row_base = row_base + stride;
                    if ((SIZE_W + 1)'(row) + 1'b1 >= (SIZE_W + 1)'(rows)) begin
                        n_row        = '0;
                        n_row_base   = '0;
                        n_plane_done = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        n_offset = r_s1_xsum + OFF_W'(line_off);
        if (r_s1_sel == PLANE_CHROMA) begin
            n_offset = n_offset + r_plane_size;
        end
        if (r_s1_done) begin
            n_offset = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout     <= LAYOUT_MB16;
            r_width      <= SIZE_W'(1920);
            r_height     <= SIZE_W'(1088);
            r_cur_plane  <= PLANE_LUMA;
            r_plane_done <= 1'b0;
            r_byte       <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_row_base   <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index inside
                    {CFG_TILE_LAYOUT, CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT})) begin
                case (i_cfg_index)
                    CFG_TILE_LAYOUT:  r_layout <= i_cfg_data[0];
                    CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default:          r_layout <= r_layout;
                endcase
                r_plane_done <= 1'b0;
                r_byte       <= '0;
                r_col        <= '0;
                r_row        <= '0;
                r_row_base   <= '0;
            end else if (acc) begin
                r_cur_plane  <= sel;
                r_plane_done <= n_plane_done;
                r_byte       <= n_byte;
                r_col        <= n_col;
                r_row        <= n_row;
                r_row_base   <= n_row_base;
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane_size <= OFF_W'(plane_area);
        if (acc) begin
            r_s1_sel  <= sel;
            r_s1_done <= done;
            r_s1_pix  <= i_in_data.pixel_byte;
            r_s1_xsum <= n_xsum;
            r_s1_ymul <= n_ymul;
        end
        if (adv && r_s1_valid) begin
            r_out.dest_offset  <= n_offset;
            r_out.pixel_out    <= r_s1_pix;
            r_out.beyond_frame <= r_s1_done;
        end
    end

    always_comb begin
        if (r_layout == LAYOUT_MB16) begin
            cols_cur = w_eff >> 4;
        end else if (r_cur_plane == PLANE_LUMA) begin
            cols_cur = w_eff >> 2;
        end else begin
            cols_cur = w_eff >> 3;
        end
    end

`ifndef NO_ASSERTIONS
    a_beyond_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.beyond_frame) |-> (o_out_data.dest_offset == '0))
        else $error("beyond-frame transaction with nonzero offset");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plane_done |-> (r_byte == 8'd0 && r_col == '0 && r_row == '0 && r_row_base == '0))
        else $error("counters not cleared at plane end");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SIZE_W + 1)'(r_col) < (SIZE_W + 1)'(cols_cur))
        else $error("tile column past frame width");

    a_tile4_luma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_layout == LAYOUT_TILE4 && r_cur_plane == PLANE_LUMA) |-> (r_byte < 8'd16))
        else $error("byte index past 4x4 tile");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_s1_valid) |=> r_s1_valid)
        else $error("stage 1 lost during output stall");
`endif

endmodule

// ===== tb/sv/tiled_yuv_to_nv12_address_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tiled_yuv_to_nv12_address_test
// Self-checking bench for the tiled frame to NV12 address generator. A queue
// of tiled source bytes feeds a valid/ready driver. Each accepted byte runs
// through a local model of the detiler, whose offsets are checked in order
// against the output stream. Register settings cover both layouts, odd and
// clamped frame sizes, and small frames where whole planes and the bytes past
// their end go through.
// ----------------------------------------------------------------------------
module tiled_yuv_to_nv12_address_test;
    import tyuv_pkg::*;

    localparam int FRAME_CAP_W = 4096;
    localparam int FRAME_CAP_H = 4096;
    localparam int QUIET_LIMIT = 2000;
    localparam int BYTE_TARGET = 1500;
    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [SIZE_W-1:0] i_cfg_data = '0;

    tiled_yuv_to_nv12_address #(
        .MAX_WIDTH  (FRAME_CAP_W),
        .MAX_HEIGHT (FRAME_CAP_H)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // detiler model state
    logic              lay = LAYOUT_MB16;
    logic [SIZE_W-1:0] cfg_w = SIZE_W'(1920);
    logic [SIZE_W-1:0] cfg_h = SIZE_W'(1088);
    logic [9:0]        row_cnt = '0;
    logic [9:0]        col_cnt = '0;
    logic [7:0]        tile_byte = '0;
    logic              cur_plane = PLANE_LUMA;
    bit                plane_full = 1'b0;

    t_in_item  tiled_bytes_q[$];
    t_out_item mapped_bytes_q[$];

    bit          no_idle = 1'b0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          beyond_seen = 0;
    int          cfg_writes = 0;
    int          stim_count = 0;
    int unsigned quiet = 0;

    function automatic int unsigned frame_dim(logic [SIZE_W-1:0] v, int unsigned cap_v);
        int unsigned lim;
        int unsigned s;
        lim = cap_v & ~32'd15;
        if (lim < 16) lim = 16;
        s = 32'(v) & ~32'd15;
        if (s < 16) s = 16;
        if (s > lim) s = lim;
        return s;
    endfunction

    function automatic void clear_counters();
        row_cnt = '0;
        col_cnt = '0;
        tile_byte = '0;
        plane_full = 1'b0;
    endfunction

    function automatic void apply_cfg(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        case (idx)
            CFG_TILE_LAYOUT: lay = val[0];
            CFG_FRAME_WIDTH: cfg_w = val;
            CFG_FRAME_HEIGHT: cfg_h = val;
            default: return;
        endcase
        clear_counters();
    endfunction

    function automatic void map_to_nv12(t_in_item it);
        int unsigned w, h, cols, rows, tsize, off, b, l, q, r, c, nc, nr;
        t_out_item res;
        w = frame_dim(cfg_w, FRAME_CAP_W);
        h = frame_dim(cfg_h, FRAME_CAP_H);
        if (it.plane_start || it.plane_select != cur_plane) begin
            cur_plane = it.plane_select;
            clear_counters();
        end
        res.pixel_out = it.pixel_byte;
        if (plane_full) begin
            res.dest_offset = '0;
            res.beyond_frame = 1'b1;
        end else begin
            b = 32'(tile_byte);
            if (lay == LAYOUT_MB16) begin
                cols = w / 16;
                rows = h / 16;
                l = b & 63;
                if (it.plane_select == PLANE_LUMA) begin
                    q = (b >> 6) & 3;
                    tsize = 256;
                    off = 32'(row_cnt) * 16 * w + 32'(col_cnt) * 16
                        + (q & 1) * 8 + (q >> 1) * 8 * w + (l >> 3) * w + (l & 7);
                end else begin
                    tsize = 128;
                    off = w * h + 32'(row_cnt) * 8 * w + 32'(col_cnt) * 16
                        + (l >> 3) * w + 2 * (l & 7) + ((b >> 6) & 1);
                end
            end else begin
                if (it.plane_select == PLANE_LUMA) begin
                    cols = w / 4;
                    rows = h / 4;
                    tsize = 16;
                    r = (b >> 2) & 3;
                    c = b & 3;
                    off = 32'(row_cnt) * 4 * w + 32'(col_cnt) * 4 + (3 - r) * w + (3 - c);
                end else begin
                    cols = w / 8;
                    rows = h / 8;
                    tsize = 32;
                    l = (b >> 1) & 15;
                    r = l >> 2;
                    c = l & 3;
                    off = w * h + 32'(row_cnt) * 4 * w + (32'(col_cnt) * 4 + 3 - c) * 2
                        + r * w + ((b & 1) ? 0 : 1);
                end
            end
            res.dest_offset = OFF_W'(off);
            res.beyond_frame = 1'b0;
            b = b + 1;
            if (b >= tsize) begin
                b = 0;
                nc = 32'(col_cnt) + 1;
                if (nc >= cols) begin
                    nc = 0;
                    nr = 32'(row_cnt) + 1;
                    if (nr >= rows) begin
                        nr = 0;
                        plane_full = 1'b1;
                    end
                    row_cnt = 10'(nr);
                end
                col_cnt = 10'(nc);
            end
            tile_byte = 8'(b);
        end
        mapped_bytes_q.push_back(res);
    endfunction

    task automatic check_result(t_out_item got);
        t_out_item want;
        results_seen++;
        if (mapped_bytes_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transaction: offset %0d pixel %h beyond %b",
                         got.dest_offset, got.pixel_out, got.beyond_frame);
            return;
        end
        want = mapped_bytes_q.pop_front();
        if (got.dest_offset !== want.dest_offset || got.pixel_out !== want.pixel_out
                || got.beyond_frame !== want.beyond_frame) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at result %0d: offset %0d/%0d pixel %h/%h beyond %b/%b",
                         results_seen, want.dest_offset, got.dest_offset,
                         want.pixel_out, got.pixel_out, want.beyond_frame, got.beyond_frame);
        end else if (got.beyond_frame) begin
            beyond_seen++;
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                map_to_nv12(i_in_data);
            end
            if (!i_in_valid || o_in_ready) begin
                if (tiled_bytes_q.size() > 0 && (no_idle || $urandom_range(99) >= 27)) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= tiled_bytes_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_result(o_out_data);
            end
            i_out_ready <= no_idle || $urandom_range(99) >= 27;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("no transaction for %0d cycles", QUIET_LIMIT);
                $display("tiled_yuv_to_nv12_address regression: fail");
                $finish;
            end
        end
    end

    task automatic push_byte(logic sel, logic start, logic [7:0] pix);
        t_in_item it;
        it.plane_select = sel;
        it.plane_start = start;
        it.pixel_byte = pix;
        tiled_bytes_q.push_back(it);
        stim_count++;
    endtask

    task automatic send_plane(logic sel, int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            push_byte(sel, i == 0, 8'($urandom_range(255)));
        end
    endtask

    task automatic drain();
        while (tiled_bytes_q.size() != 0 || i_in_valid || mapped_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        apply_cfg(idx, val);
        cfg_writes++;
    endtask

    function automatic logic [SIZE_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6) return 13'h1FFF;
        if (r < 12) return SIZE_W'(4096 + $urandom_range(15));
        if (r < 20) return SIZE_W'($urandom_range(15));
        if (r < 30) return SIZE_W'(16 * $urandom_range(3, 8) + $urandom_range(15));
        return SIZE_W'(16 * $urandom_range(1, 2) + $urandom_range(15));
    endfunction

    function automatic int unsigned plane_bytes(logic sel);
        int unsigned area;
        area = frame_dim(cfg_w, FRAME_CAP_W) * frame_dim(cfg_h, FRAME_CAP_H);
        return (sel == PLANE_LUMA) ? area : area / 2;
    endfunction

    initial begin
        int unsigned phase;
        int unsigned pick;
        int unsigned size;
        int unsigned n;
        logic        sel;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, macroblock layout: field extremes and plane switches
        push_byte(PLANE_LUMA, 1'b1, 8'h00);
        push_byte(PLANE_LUMA, 1'b0, 8'hFF);
        push_byte(PLANE_LUMA, 1'b0, 8'hA5);
        push_byte(PLANE_LUMA, 1'b0, 8'h5A);
        push_byte(PLANE_CHROMA, 1'b0, 8'h3C);
        push_byte(PLANE_CHROMA, 1'b0, 8'hC3);
        push_byte(PLANE_CHROMA, 1'b1, 8'h81);
        push_byte(PLANE_LUMA, 1'b0, 8'h7E);
        drain();

        // reversed tiles, width clamped to the cap, height raised to the minimum
        cfg_write(CFG_TILE_LAYOUT, 13'h1FFF);
        cfg_write(CFG_FRAME_WIDTH, 13'h1FFF);
        cfg_write(CFG_FRAME_HEIGHT, 13'h0000);
        send_plane(PLANE_LUMA, 3);
        send_plane(PLANE_CHROMA, 3);
        drain();

        // unused index must leave the counters running
        cfg_write(CFG_SPARE, 13'h0A5A);
        push_byte(PLANE_CHROMA, 1'b0, 8'h11);
        push_byte(PLANE_CHROMA, 1'b0, 8'hEE);
        drain();

        cfg_write(CFG_FRAME_WIDTH, SIZE_W'(4111));
        cfg_write(CFG_FRAME_HEIGHT, SIZE_W'(23));
        cfg_write(CFG_TILE_LAYOUT, 13'h1FFE);
        send_plane(PLANE_LUMA, 3);
        drain();
        // write mid-plane: counters restart, plane kept
        cfg_write(CFG_FRAME_HEIGHT, SIZE_W'(16));
        push_byte(PLANE_LUMA, 1'b0, 8'h42);
        push_byte(PLANE_LUMA, 1'b0, 8'hBD);
        drain();

        phase = 0;
        while (stim_count < BYTE_TARGET) begin
            drain();
            no_idle = (phase >= 3 && phase < 6);
            if ($urandom_range(1)) cfg_write(CFG_FRAME_WIDTH, pick_dim());
            cfg_write(CFG_FRAME_HEIGHT, pick_dim());
            if ($urandom_range(3) == 0) cfg_write(CFG_SPARE, SIZE_W'($urandom_range(8191)));
            cfg_write(CFG_TILE_LAYOUT, SIZE_W'($urandom_range(8191)));
            if ($urandom_range(1)) cfg_write(CFG_FRAME_WIDTH, pick_dim());
            repeat ($urandom_range(1, 4)) begin
                pick = $urandom_range(99);
                sel = 1'($urandom_range(1));
                size = plane_bytes(sel);
                if (pick < 75) begin
                    if (size <= 600) send_plane(sel, size + $urandom_range(4));
                    else send_plane(sel, $urandom_range(16, 200));
                end else if (pick < 88) begin
                    n = $urandom_range(1, (size < 200) ? size : 200);
                    send_plane(sel, n);
                    repeat ($urandom_range(1, 40))
                        push_byte(!sel, 1'b0, 8'($urandom_range(255)));
                end else begin
                    repeat ($urandom_range(1, 12))
                        push_byte(1'($urandom_range(1)), $urandom_range(99) < 15,
                                  8'($urandom_range(255)));
                end
            end
            phase++;
        end

        while (tiled_bytes_q.size() != 0 || i_in_valid || mapped_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d bytes checked, %0d flagged past the plane end", results_seen, beyond_seen);
        $display("%0d register writes over %0d random settings, both tile layouts",
                 cfg_writes, phase);
        if (mismatches == 0 && mapped_bytes_q.size() == 0) begin
            $display("tiled_yuv_to_nv12_address regression: pass");
        end else begin
            $display("tiled_yuv_to_nv12_address regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/tyuv_pkg.sv
src/tiled_yuv_to_nv12_address.sv
tb/sv/tiled_yuv_to_nv12_address_test.sv
